>>> rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared definitions for the sorted key table
// Field widths, request and status codes, and the structs that pass between
// the table control and its chain of storage cells.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned KEY_W        = 31;
  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam int unsigned DEF_CAPACITY = 16;

  // Request modes; the fourth code is unused and does nothing.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } skt_mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } skt_status_e;

  // Insert broadcast seen by every cell in the same cycle.
  typedef struct packed {
    logic                en;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } skt_ins_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic                gt;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } skt_link_t;

endpackage

>>> rtl/core/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one storage cell of the sorted key table
// Holds one key and handle, compares its key with an inserted key, and either
// keeps its entry, takes the new entry, or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic              clk_i,
  input  skt_pkg::skt_ins_t  ins_i,
  input  logic              occupied_i,
  input  skt_pkg::skt_link_t left_i,
  output skt_pkg::skt_link_t cell_o
);
  import skt_pkg::*;

  logic [KEY_W-1:0]    key_q, key_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                gt;
  logic                take_new;
  logic                shift;

  // An empty cell, or one holding a strictly greater key, lies at or beyond
  // the insert slot. The slot itself is the first such cell.
  always_comb begin
    gt       = !occupied_i || (key_q > ins_i.key);
    take_new = ins_i.en && gt && !left_i.gt;
    shift    = ins_i.en && left_i.gt;
  end

  // Next entry of this cell.
  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (shift) begin
      key_d    = left_i.key;
      handle_d = left_i.handle;
    end else if (take_new) begin
      key_d    = ins_i.key;
      handle_d = ins_i.handle;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign cell_o.gt     = gt;
  assign cell_o.key    = key_q;
  assign cell_o.handle = handle_q;

endmodule

>>> rtl/core/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: table of key and handle entries kept in ascending key order
// A row of cells compares an inserted key in parallel and shifts the later entries.
// ----------------------------------------------------------------------------
// busy_o is always low, so a request may be issued in every cycle, and its
// result appears on the result ports with done_o high in the cycle after
// start_i. The receiver cannot stall; done_o marks a result for that one
// cycle only, and the result stays on the ports until the next request. An
// insert compares the new key in every cell at once and each cell beyond the
// slot takes its left neighbor's entry, so the row of CAPACITY cells sets the
// cycle. Equal keys keep arrival order. A read returns the entry at position;
// positions at or above the count report out of range. A clear empties the
// count only. entry_count_o reports the count after the request, in five bits.
module sorted_key_table #(
  parameter int unsigned CAPACITY = skt_pkg::DEF_CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [skt_pkg::MODE_W-1:0]    mode_i,
  input  logic [skt_pkg::KEY_W-1:0]     key_i,
  input  logic [skt_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [skt_pkg::POS_W-1:0]     position_i,
  output logic                          done_o,
  output logic [skt_pkg::STATUS_W-1:0]  status_o,
  output logic [skt_pkg::HANDLE_W-1:0]  handle_out_o,
  output logic [skt_pkg::KEY_W-1:0]     key_out_o,
  output logic [skt_pkg::COUNT_OUT_W-1:0] entry_count_o
);
  import skt_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W  = CNT_W + POS_W;
  localparam int unsigned READ_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  skt_status_e      status_q, status_d;
  logic [HANDLE_W-1:0] handle_out_q, handle_out_d;
  logic [KEY_W-1:0]    key_out_q, key_out_d;

  skt_ins_t  ins;
  skt_link_t links [CAPACITY+1];
  logic      full;
  logic      in_range;
  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] cnt_ext;
  logic [EXT_W+COUNT_OUT_W-1:0] cnt_out_ext;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;

  // Full and range checks against the current count.
  always_comb begin
    full     = (count_q == CNT_W'(CAPACITY));
    pos_ext  = EXT_W'(position_i);
    cnt_ext  = EXT_W'(count_q);
    in_range = (pos_ext < cnt_ext) && (pos_ext < EXT_W'(CAPACITY));
  end

  // Insert broadcast to the cell row.
  always_comb begin
    ins.en     = start_i && !busy_o && (mode_i == MODE_INSERT) && !full;
    ins.key    = key_i;
    ins.handle = handle_i;
  end

  // The row of cells; the leftmost cell sees a neighbor that never shifts in.
  assign links[0].gt     = 1'b0;
  assign links[0].key    = '0;
  assign links[0].handle = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic occupied;
    assign occupied = (CNT_W'(g) < count_q);
    skt_cell u_cell (
      .clk_i      (clk_i),
      .ins_i      (ins),
      .occupied_i (occupied),
      .left_i     (links[g]),
      .cell_o     (links[g+1])
    );
  end

  // Read select over the cells that a position can address.
  always_comb begin
    rd_key    = '0;
    rd_handle = '0;
    for (int unsigned j = 0; j < READ_N; j++) begin
      if (position_i == POS_W'(j)) begin
        rd_key    = links[j+1].key;
        rd_handle = links[j+1].handle;
      end
    end
  end

  // Result and count for the request.
  always_comb begin
    count_d      = count_q;
    status_d     = ST_OK;
    handle_out_d = '0;
    key_out_d    = '0;
    case (skt_mode_e'(mode_i))
      MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (in_range) begin
          handle_out_d = rd_handle;
          key_out_d    = rd_key;
        end else begin
          status_d = ST_RANGE;
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        count_q <= count_d;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      status_q     <= status_d;
      handle_out_q <= handle_out_d;
      key_out_q    <= key_out_d;
    end
  end

  assign cnt_out_ext   = (EXT_W+COUNT_OUT_W)'(count_q);
  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign handle_out_o  = handle_out_q;
  assign key_out_o     = key_out_q;
  assign entry_count_o = cnt_out_ext[COUNT_OUT_W-1:0];

  // The count never passes the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A result follows every accepted request in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("missing result after request");

  // A dropped insert leaves the table full.
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_q == CNT_W'(CAPACITY)))
    else $error("full status with room in table");

  // An out of range read returns a zero entry.
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_RANGE) |-> (key_out_o == '0 && handle_out_o == '0))
    else $error("out of range read returned data");

endmodule

>>> test/sorted_key_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker: request and result monitor for the sorted key table
// Watches the request and result channels, keeps its own sorted copy of the
// table, works out the answer to every accepted request and compares each
// result with the oldest answer still due, field by field.
// ----------------------------------------------------------------------------
module sorted_key_table_checker #(
  parameter int unsigned CAPACITY = skt_pkg::DEF_CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [skt_pkg::MODE_W-1:0]      mode_i,
  input  logic [skt_pkg::KEY_W-1:0]       key_i,
  input  logic [skt_pkg::HANDLE_W-1:0]    handle_i,
  input  logic [skt_pkg::POS_W-1:0]       position_i,
  input  logic                            done_i,
  input  logic [skt_pkg::STATUS_W-1:0]    status_i,
  input  logic [skt_pkg::HANDLE_W-1:0]    handle_out_i,
  input  logic [skt_pkg::KEY_W-1:0]       key_out_i,
  input  logic [skt_pkg::COUNT_OUT_W-1:0] entry_count_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o,
  output int                              full_drops_o,
  output int                              range_reads_o
);
  import skt_pkg::*;

  // One answer of the table, as it should appear on the result ports.
  typedef struct packed {
    skt_status_e            status;
    logic [HANDLE_W-1:0]    handle;
    logic [KEY_W-1:0]       key;
    logic [COUNT_OUT_W-1:0] count;
  } table_answer_t;

  logic [KEY_W-1:0]    sorted_keys [CAPACITY];
  logic [HANDLE_W-1:0] sorted_handles [CAPACITY];
  int unsigned         held_entries;
  table_answer_t       answers_due [$];
  table_answer_t       oldest_answer;

  // Applies one request to the local table and returns the answer it gives.
  function automatic table_answer_t apply_to_table(logic [MODE_W-1:0] mode,
                                                   logic [KEY_W-1:0] key,
                                                   logic [HANDLE_W-1:0] handle,
                                                   logic [POS_W-1:0] pos);
    table_answer_t answer;
    int unsigned   slot;
    answer.status = ST_OK;
    answer.handle = '0;
    answer.key    = '0;
    case (mode)
      MODE_INSERT: begin
        if (held_entries >= CAPACITY) begin
          answer.status = ST_FULL;
        end else begin
          // The new entry goes behind every entry with an equal or smaller key.
          slot = 0;
          while (slot < held_entries && sorted_keys[slot] <= key) slot++;
          for (int j = held_entries; j > slot; j--) begin
            sorted_keys[j]    = sorted_keys[j-1];
            sorted_handles[j] = sorted_handles[j-1];
          end
          sorted_keys[slot]    = key;
          sorted_handles[slot] = handle;
          held_entries++;
        end
      end
      MODE_READ: begin
        if (pos >= held_entries) begin
          answer.status = ST_RANGE;
        end else begin
          answer.handle = sorted_handles[pos];
          answer.key    = sorted_keys[pos];
        end
      end
      MODE_CLEAR: begin
        held_entries = 0;
      end
      default: begin
      end
    endcase
    answer.count = COUNT_OUT_W'(held_entries);
    return answer;
  endfunction

  // Results are checked before the request of the same edge is predicted, so
  // a result is never matched against the request accepted alongside it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_entries = 0;
      answers_due.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      full_drops_o  = 0;
      range_reads_o = 0;
    end else begin
      if (done_i) begin
        if (answers_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count_o++;
        end else begin
          oldest_answer = answers_due.pop_front();
          checked_o++;
          if (status_i !== oldest_answer.status) begin
            $error("status: expected %0d, actual %0d", oldest_answer.status, status_i);
            fail_count_o++;
          end
          if (handle_out_i !== oldest_answer.handle) begin
            $error("handle_out: expected 0x%04h, actual 0x%04h",
                   oldest_answer.handle, handle_out_i);
            fail_count_o++;
          end
          if (key_out_i !== oldest_answer.key) begin
            $error("key_out: expected 0x%08h, actual 0x%08h", oldest_answer.key, key_out_i);
            fail_count_o++;
          end
          if (entry_count_i !== oldest_answer.count) begin
            $error("entry_count: expected %0d, actual %0d",
                   oldest_answer.count, entry_count_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        answers_due.push_back(apply_to_table(mode_i, key_i, handle_i, position_i));
        if (answers_due[$].status == ST_FULL) full_drops_o++;
        if (answers_due[$].status == ST_RANGE) range_reads_o++;
      end
    end
    pending_o = answers_due.size();
  end

endmodule

>>> test/sorted_key_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb: testbench for the sorted key table
// Issues a directed set of requests covering the field extremes, equal keys,
// a full table, out of range reads, clear and the unused mode, then random
// requests in fill-heavy and read-heavy rounds. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;
  import skt_pkg::*;

  localparam int unsigned        RANDOM_ITEMS = 780;
  localparam int unsigned        CALM_ITEMS   = 150;
  localparam int unsigned        STALL_LIMIT  = 1000;
  localparam logic [MODE_W-1:0]  MODE_UNUSED  = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [MODE_W-1:0]      mode_i = MODE_INSERT;
  logic [KEY_W-1:0]       key_i = '0;
  logic [HANDLE_W-1:0]    handle_i = '0;
  logic [POS_W-1:0]       position_i = '0;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic [HANDLE_W-1:0]    handle_out_o;
  logic [KEY_W-1:0]       key_out_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;

  int fail_count;
  int pending;
  int checked;
  int full_drops;
  int range_reads;
  int inserts_sent;
  int reads_sent;
  int clears_sent;
  int unused_sent;
  int stall_cycles;
  bit may_idle = 1'b1;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_key_table #(
    .CAPACITY(DEF_CAPACITY)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .handle_i     (handle_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .handle_out_o (handle_out_o),
    .key_out_o    (key_out_o),
    .entry_count_o(entry_count_o)
  );

  sorted_key_table_checker #(
    .CAPACITY(DEF_CAPACITY)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .handle_i     (handle_i),
    .position_i   (position_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .handle_out_i (handle_out_o),
    .key_out_i    (key_out_o),
    .entry_count_i(entry_count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .full_drops_o (full_drops),
    .range_reads_o(range_reads)
  );

  // Watchdog: ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("sorted_key_table_tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Issues one request, after an optional idle burst, and returns at the edge
  // that accepts it.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                              input logic [HANDLE_W-1:0] handle,
                              input logic [POS_W-1:0] pos);
    if (may_idle && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    mode_i     <= mode;
    key_i      <= key;
    handle_i   <= handle;
    position_i <= pos;
    case (mode)
      MODE_INSERT: inserts_sent++;
      MODE_READ:   reads_sent++;
      MODE_CLEAR:  clears_sent++;
      default:     unused_sent++;
    endcase
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    int unsigned         round_left;
    int unsigned         insert_weight;
    int unsigned         pick;
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    round_left    = 0;
    insert_weight = 50;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty table, extreme keys and handles, equal keys.
    send_request(MODE_READ, '0, '0, '0);
    send_request(MODE_INSERT, '1, 16'hFFFF, '0);
    send_request(MODE_INSERT, '0, 16'h0000, '0);
    send_request(MODE_INSERT, 31'd1, 16'h1111, '0);
    send_request(MODE_INSERT, 31'd1, 16'h2222, '0);
    for (int p = 0; p < 4; p++) send_request(MODE_READ, '0, '0, POS_W'(p));
    send_request(MODE_READ, '0, '0, '1);
    send_request(MODE_UNUSED, '1, '1, '1);
    // Fill to capacity with falling keys so that each lands near the front.
    for (int i = 0; i < 12; i++) begin
      send_request(MODE_INSERT, KEY_W'(600 - 40 * i), HANDLE_W'(i), '0);
    end
    send_request(MODE_INSERT, 31'd5, 16'hABCD, '0);
    send_request(MODE_READ, '0, '0, '1);
    send_request(MODE_CLEAR, '1, '1, '1);
    send_request(MODE_READ, '0, '0, '0);

    // Random part in rounds that lean toward filling or toward reading.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (round_left == 0) begin
        round_left    = $urandom_range(20, 60);
        insert_weight = $urandom_range(0, 1) ? 70 : 30;
      end
      round_left--;
      may_idle = (n < RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) mode = MODE_INSERT;
      else if (pick < 95) mode = MODE_READ;
      else if (pick < 98) mode = MODE_CLEAR;
      else mode = MODE_UNUSED;
      // Narrow keys give many equal keys; the rest span the whole range.
      case ($urandom_range(0, 3))
        0: key = KEY_W'($urandom_range(0, 15));
        1: key = $urandom_range(0, 1) ? '1 : KEY_W'($urandom_range(0, 1));
        default: key = KEY_W'($urandom() >> 1);
      endcase
      send_request(mode, key, HANDLE_W'($urandom_range(0, 65535)),
                   POS_W'($urandom_range(0, 15)));
    end

    // Drain the last result, then keep watching for stray strobes.
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d inserts, %0d reads, %0d clears and %0d unused-mode requests.",
             inserts_sent, reads_sent, clears_sent, unused_sent);
    $display("Compared %0d results, %0d inserts dropped on a full table, %0d reads out of range.",
             checked, full_drops, range_reads);
    if (fail_count == 0) begin
      $display("sorted_key_table_tb: clean");
    end else begin
      $display("sorted_key_table_tb: errors");
    end
    $finish;
  end

endmodule
